// File: hw/rtl/itoa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg: shared definitions of the integer to ASCII radix unit
// Word width, field widths, character codes and the digit to character map.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int WORD_BITS  = 32;
    localparam int RADIX_W    = 8;
    localparam int DIGIT_W    = 6;
    localparam int CHAR_W     = 7;
    localparam int CNT_W      = $clog2(WORD_BITS + 1);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int IN_TDATA_W = ((WORD_BITS + RADIX_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((CHAR_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_A     = 7'h61;
    localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
    localparam logic [CHAR_W-1:0] CH_B     = 7'h62;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;
    localparam logic [CHAR_W-1:0] CH_NONE  = 7'h00;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 8'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 8'd36;
    localparam logic [RADIX_W-1:0] RADIX_BIN = 8'd2;
    localparam logic [RADIX_W-1:0] RADIX_OCT = 8'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 8'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 8'd16;

    // Maps a digit value 0..35 to '0'..'9' or 'a'..'z'.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] w_d;
        w_d = {1'b0, d};
        if (d < 6'd10) begin
            digit_char = CH_ZERO + w_d;
        end else begin
            digit_char = CH_A + w_d - 7'd10;
        end
    endfunction

endpackage

// File: hw/rtl/integer_to_ascii_radix_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_unit: integer to ASCII text in radix 2..36
// Bit-serial division extracts digits into a shift-register stack, which is
// then unloaded most significant digit first behind any sign and prefix.
// ----------------------------------------------------------------------------
// Each input word carries a 32-bit value and an 8-bit radix; the unit answers
// with the text of the value as a run of output words, one ASCII character per
// word, most significant character first, with tlast on the final character.
// Radix 10 reads the value as signed and puts '-' first when it is negative;
// every other radix converts the unsigned pattern, radix 16 led by "0x", radix
// 8 by "0" and radix 2 by "0b". A zero value in a valid radix gives '0' alone.
// A radix outside 2..36 gives a single word with tuser (error) set, character
// zero and tlast set. One value is converted at a time: the input is ready
// only while the unit is idle, though the last character may still be waiting
// in the output register. Division extracts one digit per full word pass,
// because the divider is a restoring divider that retires one quotient bit
// per cycle; then the sign and prefix slots are stepped through in turn and
// the digits are emitted as the output side takes them. A bad radix skips
// division and goes straight to the error word.
module integer_to_ascii_radix_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // Fields from bit 0 up: value (32 bits, signed in radix 10), radix (8 bits).
    input  logic [itoa_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // Fields from bit 0 up: char_code (7 bits), one zero pad bit.
    output logic [itoa_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                                o_m_axis_tlast,
    // Fields from bit 0 up: error (1 bit).
    output logic [0:0]                          o_m_axis_tuser
);

    localparam int W  = itoa_pkg::WORD_BITS;
    localparam int CW = itoa_pkg::CNT_W;
    localparam int BW = itoa_pkg::BIT_W;
    localparam int DW = itoa_pkg::DIGIT_W;
    localparam int RW = itoa_pkg::RADIX_W;
    localparam int KW = itoa_pkg::CHAR_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_PRE  = 3'd2;
    localparam logic [2:0] ST_DIG  = 3'd3;
    localparam logic [2:0] ST_ERR  = 3'd4;

    localparam logic [1:0] STEP_SIGN = 2'd0;
    localparam logic [1:0] STEP_P0   = 2'd1;
    localparam logic [1:0] STEP_P1   = 2'd2;

    logic [2:0]          r_state, n_state;
    logic [W-1:0]        r_quot, n_quot;
    logic [DW-1:0]       r_rem, n_rem;
    logic [DW-1:0]       r_radix, n_radix;
    logic [BW-1:0]       r_bit, n_bit;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [DW-1:0]       r_stack [W];
    logic [DW-1:0]       n_stack [W];
    logic                r_neg, n_neg;
    logic                r_pfx0, n_pfx0;
    logic                r_pfx1, n_pfx1;
    logic [KW-1:0]       r_pfx1_char, n_pfx1_char;
    logic [1:0]          r_step, n_step;
    logic                r_out_valid, n_out_valid;
    logic [KW-1:0]       r_out_char, n_out_char;
    logic                r_out_last, n_out_last;
    logic                r_out_err, n_out_err;

    logic                w_accept;
    logic                w_slot;
    logic [W-1:0]        w_value;
    logic [RW-1:0]       w_radix;
    logic                w_bad;
    logic                w_in_neg;
    logic [W-1:0]        w_mag;
    logic [DW:0]         w_trial;
    logic                w_ge;
    logic [DW:0]         w_diff;
    logic [DW-1:0]       w_rem_next;
    logic [W-1:0]        w_quot_next;
    logic [CW-1:0]       w_cnt_inc;
    logic                w_emit;
    logic [KW-1:0]       w_emit_char;

    assign w_value  = i_s_axis_tdata[W-1:0];
    assign w_radix  = i_s_axis_tdata[W+RW-1:W];
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    // The output register takes a new character when empty or being drained.
    assign w_slot   = !r_out_valid || i_m_axis_tready;

    assign w_bad    = (w_radix < itoa_pkg::RADIX_MIN) || (w_radix > itoa_pkg::RADIX_MAX);
    assign w_in_neg = (w_radix == itoa_pkg::RADIX_DEC) && w_value[W-1];
    assign w_mag    = w_in_neg ? (~w_value + {{(W-1){1'b0}}, 1'b1}) : w_value;

    // One restoring division step: shift in the next dividend bit and try
    // to subtract the radix from the partial remainder.
    assign w_trial     = {r_rem, r_quot[W-1]};
    assign w_ge        = w_trial >= {1'b0, r_radix};
    assign w_diff      = w_trial - {1'b0, r_radix};
    assign w_rem_next  = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
    assign w_quot_next = {r_quot[W-2:0], w_ge};
    assign w_cnt_inc   = r_cnt + {{(CW-1){1'b0}}, 1'b1};

    // Which prefix slot speaks in the current step, and with what.
    always_comb begin
        w_emit      = 1'b0;
        w_emit_char = itoa_pkg::CH_NONE;
        case (r_step)
            STEP_SIGN: begin
                w_emit      = r_neg;
                w_emit_char = itoa_pkg::CH_MINUS;
            end
            STEP_P0: begin
                w_emit      = r_pfx0;
                w_emit_char = itoa_pkg::CH_ZERO;
            end
            STEP_P1: begin
                w_emit      = r_pfx1;
                w_emit_char = r_pfx1_char;
            end
            default: begin
                w_emit      = 1'b0;
                w_emit_char = itoa_pkg::CH_NONE;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_quot      = r_quot;
        n_rem       = r_rem;
        n_radix     = r_radix;
        n_bit       = r_bit;
        n_cnt       = r_cnt;
        n_stack     = r_stack;
        n_neg       = r_neg;
        n_pfx0      = r_pfx0;
        n_pfx1      = r_pfx1;
        n_pfx1_char = r_pfx1_char;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_err   = r_out_err;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_radix = w_radix[DW-1:0];
                    n_quot  = w_mag;
                    n_rem   = '0;
                    n_bit   = BW'(W - 1);
                    n_step  = STEP_SIGN;
                    if (w_bad) begin
                        n_state = ST_ERR;
                    end else if (w_mag == '0) begin
                        // Zero is a lone '0' digit with no sign or prefix.
                        n_stack[0] = '0;
                        n_cnt      = {{(CW-1){1'b0}}, 1'b1};
                        n_neg      = 1'b0;
                        n_pfx0     = 1'b0;
                        n_pfx1     = 1'b0;
                        n_state    = ST_PRE;
                    end else begin
                        n_cnt       = '0;
                        n_neg       = w_in_neg;
                        n_pfx0      = (w_radix == itoa_pkg::RADIX_HEX) ||
                                      (w_radix == itoa_pkg::RADIX_OCT) ||
                                      (w_radix == itoa_pkg::RADIX_BIN);
                        n_pfx1      = (w_radix == itoa_pkg::RADIX_HEX) ||
                                      (w_radix == itoa_pkg::RADIX_BIN);
                        n_pfx1_char = (w_radix == itoa_pkg::RADIX_HEX) ?
                                      itoa_pkg::CH_X : itoa_pkg::CH_B;
                        n_state     = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_quot = w_quot_next;
                if (r_bit == '0) begin
                    // Word pass done: the remainder is the next digit, pushed
                    // onto the stack so that it unloads last-in first-out.
                    for (int k = W - 1; k > 0; k--) begin
                        n_stack[k] = r_stack[k-1];
                    end
                    n_stack[0] = w_rem_next;
                    n_cnt      = w_cnt_inc;
                    n_rem      = '0;
                    n_bit      = BW'(W - 1);
                    if ((w_quot_next == '0) || (w_cnt_inc == CW'(W))) begin
                        n_state = ST_PRE;
                    end
                end else begin
                    n_rem = w_rem_next;
                    n_bit = r_bit - {{(BW-1){1'b0}}, 1'b1};
                end
            end
            ST_PRE: begin
                if (!w_emit || w_slot) begin
                    if (w_emit) begin
                        n_out_valid = 1'b1;
                        n_out_char  = w_emit_char;
                        n_out_last  = 1'b0;
                        n_out_err   = 1'b0;
                    end
                    if (r_step == STEP_P1) begin
                        n_state = ST_DIG;
                    end else begin
                        n_step = r_step + 2'd1;
                    end
                end
            end
            ST_DIG: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_char  = itoa_pkg::digit_char(r_stack[0]);
                    n_out_last  = (r_cnt == {{(CW-1){1'b0}}, 1'b1});
                    n_out_err   = 1'b0;
                    for (int k = 0; k < W - 1; k++) begin
                        n_stack[k] = r_stack[k+1];
                    end
                    n_cnt = r_cnt - {{(CW-1){1'b0}}, 1'b1};
                    if (r_cnt == {{(CW-1){1'b0}}, 1'b1}) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_ERR: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_char  = itoa_pkg::CH_NONE;
                    n_out_last  = 1'b1;
                    n_out_err   = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_bit       <= '0;
            r_step      <= STEP_SIGN;
            r_out_valid <= 1'b0;
            r_neg       <= 1'b0;
            r_quot      <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_bit       <= n_bit;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            r_neg       <= n_neg;
            r_quot      <= n_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem       <= n_rem;
        r_radix     <= n_radix;
        r_stack     <= n_stack;
        r_pfx0      <= n_pfx0;
        r_pfx1      <= n_pfx1;
        r_pfx1_char <= n_pfx1_char;
        r_out_char  <= n_out_char;
        r_out_last  <= n_out_last;
        r_out_err   <= n_out_err;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(itoa_pkg::OUT_TDATA_W - KW){1'b0}}, r_out_char};
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_err;

`ifndef SYNTHESIS
    // The digit count never exceeds the width of the stack.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(W))
        else $error("digit count beyond stack depth");

    // Unloading digits always has at least one digit left.
    a_dig_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIG) |-> (r_cnt != '0))
        else $error("digit unload with empty stack");

    // The partial remainder stays below the radix during division.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_radix))
        else $error("division remainder out of range");

    // An error word is a lone zero character that ends its run.
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |->
        (o_m_axis_tlast && (o_m_axis_tdata == '0)))
        else $error("malformed error word");

    // An accepted word always starts work, so the input closes next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_axis_tready)
        else $error("input still ready after accept");
`endif

endmodule

// File: tb/sv/integer_to_ascii_radix_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_unit_tb: self-checking bench for the radix text unit
// Feeds value and radix words, predicts the character stream of each one and
// checks every output word in order, under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_unit_tb;

    localparam int WORD_BITS   = itoa_pkg::WORD_BITS;
    localparam int RADIX_W     = itoa_pkg::RADIX_W;
    localparam int DIGIT_W     = itoa_pkg::DIGIT_W;
    localparam int CHAR_W      = itoa_pkg::CHAR_W;
    localparam int IN_TDATA_W  = itoa_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = itoa_pkg::OUT_TDATA_W;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 9;
    localparam int RANDOM_WORDS    = 200;
    // The limit covers about 225 words of the slowest legal conversions, plus
    // stalls on up to 34 characters per word, several times over.
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int HOLD_OFF_AFTER  = 300;
    localparam int SETTLE_CYCLES   = 100;
    localparam int MAX_REPORTS     = 10;

    // One character of expected or observed text.
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
        logic              err;
    } t_text_char;

    // One entry of the send queue; a drain entry makes the sender wait until
    // every outstanding character has come back.
    typedef struct {
        logic [WORD_BITS-1:0] value;
        logic [RADIX_W-1:0]   radix;
        bit                   drain;
    } t_conv_req;

    // Output-side ready behavior, chosen afresh at random intervals.
    typedef enum int {RX_STEADY, RX_LIGHT, RX_HEAVY} t_rx_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;
    logic [0:0]             o_m_axis_tuser;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    integer_to_ascii_radix_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    t_text_char chars_due[$];
    t_conv_req  words_to_send[$];

    int       words_taken = 0;
    int       bad_radix_words = 0;
    int       chars_checked = 0;
    int       mismatches = 0;
    int       longest_text = 0;
    int       cycle_count = 0;
    int       drains_done = 0;
    int       burst_left = 1;
    int       gap_left = 0;
    int       hold_left = 0;
    int       stall_phase = 0;
    t_rx_mode stall_mode = RX_STEADY;
    bit       word_taken = 1'b0;
    bit       hold_off_done = 1'b0;

    // Works out the text that one input word must produce and appends it to
    // the queue of characters due. Digits are pulled off least significant
    // first by repeated division, then emitted in reverse behind the sign and
    // the radix prefix.
    function automatic void spell_value(input logic [WORD_BITS-1:0] value,
                                        input logic [RADIX_W-1:0] radix);
        logic [CHAR_W-1:0]    text [0:WORD_BITS+2];
        logic [DIGIT_W-1:0]   digits [0:WORD_BITS-1];
        logic [WORD_BITS-1:0] mag;
        logic [WORD_BITS-1:0] base;
        logic                 neg;
        int                   n;
        int                   nd;
        int                   k;
        n  = 0;
        nd = 0;
        if (radix < itoa_pkg::RADIX_MIN || radix > itoa_pkg::RADIX_MAX) begin
            // A bad radix answers with one flagged, empty character.
            chars_due.push_back('{code: itoa_pkg::CH_NONE, last: 1'b1, err: 1'b1});
            bad_radix_words++;
            return;
        end
        base = WORD_BITS'(radix);
        neg  = (radix == itoa_pkg::RADIX_DEC) && value[WORD_BITS-1];
        // The most negative value negates to itself, which read unsigned is
        // exactly its magnitude.
        mag  = neg ? -value : value;
        if (mag == '0) begin
            // Zero is a lone '0' in every radix, with no sign or prefix.
            text[0] = itoa_pkg::CH_ZERO;
            n = 1;
        end else begin
            while (mag != '0) begin
                digits[nd] = DIGIT_W'(mag % base);
                nd++;
                mag = mag / base;
            end
            if (neg) begin
                text[n] = itoa_pkg::CH_MINUS;
                n++;
            end
            if (radix == itoa_pkg::RADIX_HEX) begin
                text[n]     = itoa_pkg::CH_ZERO;
                text[n + 1] = itoa_pkg::CH_X;
                n += 2;
            end else if (radix == itoa_pkg::RADIX_OCT) begin
                text[n] = itoa_pkg::CH_ZERO;
                n++;
            end else if (radix == itoa_pkg::RADIX_BIN) begin
                text[n]     = itoa_pkg::CH_ZERO;
                text[n + 1] = itoa_pkg::CH_B;
                n += 2;
            end
            for (k = nd - 1; k >= 0; k--) begin
                if (digits[k] < DIGIT_W'(10)) begin
                    text[n] = itoa_pkg::CH_ZERO + CHAR_W'(digits[k]);
                end else begin
                    text[n] = itoa_pkg::CH_A + CHAR_W'(digits[k]) - CHAR_W'(10);
                end
                n++;
            end
        end
        for (k = 0; k < n; k++) begin
            chars_due.push_back('{code: text[k], last: (k == n - 1), err: 1'b0});
        end
        if (n > longest_text) begin
            longest_text = n;
        end
    endfunction

    // Appends one conversion request to the send queue.
    task automatic queue_word(input logic [WORD_BITS-1:0] value,
                              input logic [RADIX_W-1:0] radix);
        words_to_send.push_back('{value: value, radix: radix, drain: 1'b0});
    endtask

    // Monitor: at each rising edge, an accepted input word is turned into its
    // expected characters, and an accepted output word is compared, field by
    // field, with the oldest character still due.
    always @(posedge i_clk) begin
        t_text_char got;
        t_text_char want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                spell_value(i_s_axis_tdata[WORD_BITS-1:0],
                            i_s_axis_tdata[WORD_BITS +: RADIX_W]);
                words_taken++;
                word_taken = 1'b1;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = '{code: o_m_axis_tdata[CHAR_W-1:0], last: o_m_axis_tlast,
                        err: o_m_axis_tuser[0]};
                chars_checked++;
                if (chars_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("Unexpected character word %0d: code %h last %b error %b",
                                 chars_checked, got.code, got.last, got.err);
                    end
                end else begin
                    want = chars_due.pop_front();
                    if (got.code !== want.code || got.last !== want.last ||
                        got.err !== want.err) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display({"Mismatch on character word %0d: expected code %h ",
                                      "last %b error %b, got code %h last %b error %b"},
                                     chars_checked, want.code, want.last, want.err,
                                     got.code, got.last, got.err);
                        end
                    end
                end
            end
        end
    end

    // Input driver: offers words from the send queue in bursts of random
    // length separated by random gaps, and holds each word until it is taken.
    // A drain entry keeps the input idle until all characters have returned.
    always @(negedge i_clk) begin
        t_conv_req              req;
        logic [IN_TDATA_W-1:0]  packed_word;
        if (i_rst_n && (!i_s_axis_tvalid || word_taken)) begin
            word_taken = 1'b0;
            if (gap_left > 0) begin
                i_s_axis_tvalid <= 1'b0;
                gap_left--;
            end else if (words_to_send.size() == 0) begin
                i_s_axis_tvalid <= 1'b0;
            end else if (words_to_send[0].drain) begin
                i_s_axis_tvalid <= 1'b0;
                if (chars_due.size() == 0) begin
                    void'(words_to_send.pop_front());
                    drains_done++;
                end
            end else begin
                req = words_to_send.pop_front();
                packed_word = '0;
                packed_word[WORD_BITS-1:0] = req.value;
                packed_word[WORD_BITS +: RADIX_W] = req.radix;
                i_s_axis_tdata  <= packed_word;
                i_s_axis_tvalid <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 8);
                    // About a third of the bursts run straight into the next.
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
                end
            end
        end
    end

    // Output side: ready follows a mode that is picked afresh at random intervals
    // (always ready, rare stalls, frequent stalls). Once, after 300 characters, ready
    // is held low for a long stretch while the sender keeps offering words, so the
    // unit backs up and stops taking input.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left--;
        end else if (!hold_off_done && chars_checked >= HOLD_OFF_AFTER) begin
            hold_off_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (stall_phase == 0) begin
                stall_mode  = t_rx_mode'($urandom_range(0, 2));
                stall_phase = $urandom_range(20, 80);
            end
            stall_phase--;
            case (stall_mode)
                RX_STEADY: begin
                    i_m_axis_tready <= 1'b1;
                end
                RX_LIGHT: begin
                    i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    // Watchdog: a run that has not finished by the limit has hung.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run did not finish within %0d cycles.", CYCLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus: reset, a directed set of corner cases, then random words with
    // a full drain of the unit half way through.
    initial begin
        int                   i;
        int                   pick;
        int                   w;
        logic [WORD_BITS-1:0] value;
        logic [RADIX_W-1:0]   radix;

        // Zero in several radixes, including the prefixed ones.
        queue_word(32'h0000_0000, itoa_pkg::RADIX_DEC);
        queue_word(32'h0000_0000, itoa_pkg::RADIX_BIN);
        queue_word(32'h0000_0000, itoa_pkg::RADIX_HEX);
        queue_word(32'h0000_0000, itoa_pkg::RADIX_OCT);
        // Signed extremes in decimal, the most negative value among them.
        queue_word(32'h7fff_ffff, itoa_pkg::RADIX_DEC);
        queue_word(32'h8000_0000, itoa_pkg::RADIX_DEC);
        queue_word(32'hffff_ffff, itoa_pkg::RADIX_DEC);
        queue_word(32'hffff_ffd6, itoa_pkg::RADIX_DEC);
        // Other radixes read the pattern unsigned, so no minus sign here.
        queue_word(32'hffff_ffd6, itoa_pkg::RADIX_HEX);
        queue_word(32'hffff_ffff, itoa_pkg::RADIX_HEX);
        queue_word(32'hffff_ffff, itoa_pkg::RADIX_BIN);
        queue_word(32'h8000_0000, itoa_pkg::RADIX_OCT);
        queue_word(32'hdead_beef, itoa_pkg::RADIX_HEX);
        queue_word(32'h1234_5678, itoa_pkg::RADIX_OCT);
        queue_word(32'h0000_0001, itoa_pkg::RADIX_BIN);
        // Unprefixed radixes, the letter digits and the widest radix.
        queue_word(32'h0000_000a, 8'd11);
        queue_word(32'h0000_0023, itoa_pkg::RADIX_MAX);
        queue_word(32'hffff_ffff, itoa_pkg::RADIX_MAX);
        queue_word(32'h8000_0000, 8'd3);
        // Bad radixes on both sides of the valid range, zero value too.
        queue_word(32'h0000_0000, itoa_pkg::RADIX_MIN - 8'd2);
        queue_word(32'h0000_0005, itoa_pkg::RADIX_MIN - 8'd1);
        queue_word(32'h8000_0000, itoa_pkg::RADIX_MAX + 8'd1);
        queue_word(32'hffff_ffff, 8'hff);

        for (i = 0; i < RANDOM_WORDS; i++) begin
            if (i == RANDOM_WORDS / 2) begin
                words_to_send.push_back('{value: '0, radix: '0, drain: 1'b1});
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // Radix codes 0 or 1 just under the valid range, or any above.
                radix = ($urandom_range(0, 2) == 0) ? RADIX_W'($urandom_range(0, 1))
                                                     : RADIX_W'($urandom_range(37, 255));
            end else if (pick < 38) begin
                radix = itoa_pkg::RADIX_DEC;
            end else if (pick < 53) begin
                radix = itoa_pkg::RADIX_HEX;
            end else if (pick < 63) begin
                radix = itoa_pkg::RADIX_OCT;
            end else if (pick < 73) begin
                radix = itoa_pkg::RADIX_BIN;
            end else begin
                radix = RADIX_W'($urandom_range(itoa_pkg::RADIX_MIN, itoa_pkg::RADIX_MAX));
            end
            // Mostly short values keep binary conversions quick; full-width
            // random patterns still make every bit of the value toggle.
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                value = '0;
            end else if (pick <= 8) begin
                value = $urandom;
            end else begin
                w = $urandom_range(1, 16);
                value = $urandom & ((32'h1 << w) - 32'h1);
                if ($urandom_range(0, 1) == 1) begin
                    value = -value;
                end
            end
            queue_word(value, radix);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (words_to_send.size() != 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (chars_due.size() != 0) @(posedge i_clk);
        // Quiet time to catch any stray word after the last expected one.
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Converted %0d words (%0d with a bad radix) into %0d characters.",
                 words_taken, bad_radix_words, chars_checked);
        $display({"Longest text %0d characters; %0d output hold-off, ",
                  "%0d input drain; %0d mismatches."},
                 longest_text, hold_off_done, drains_done, mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
